>>> src/hsfc_pkg.sv
// Shared types, constants and a helper function for the half/single converter.
`default_nettype none

package hsfc_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned MantWidth = 24;

  localparam logic [7:0] HalfToSglRebias = 8'd112;
  localparam logic [7:0] SubnExpStart    = 8'd113;
  localparam logic [7:0] SglExpAllOnes   = 8'hFF;
  localparam logic [4:0] HalfExpAllOnes  = 5'h1F;
  localparam logic [7:0] SglExpZeroBelow = 8'd102;
  localparam logic [7:0] SglExpSubMax    = 8'd112;
  localparam logic [7:0] SglExpOverflow  = 8'd143;
  localparam logic [24:0] RoundAdd       = 25'h0001000;
  localparam logic [14:0] HalfInfinity   = 15'h7C00;

  localparam logic ModeHalfToSgl = 1'b0;
  localparam logic ModeSglToHalf = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF
  } cls_t;

  typedef struct packed {
    logic                 mode;
    logic                 sign;
    cls_t                 cls;
    logic [7:0]           expo;
    logic [MantWidth-1:0] mant;
    logic [3:0]           shamt;
  } stage_t;

  // Leading zeros of a non-zero ten-bit half mantissa.
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] cnt;
    cnt = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        cnt = 4'(9 - i);
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

>>> src/hsfc_decode.sv
// First stage: unpacks the source word, classifies it and works out exponent and shift.
`default_nettype none

module hsfc_decode (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  mode,
  input  wire logic [31:0]           operand_bits,
  output logic                       dec_valid,
  output hsfc_pkg::stage_t           dec
);

  hsfc_pkg::stage_t dec_next;
  logic [4:0]       e5;
  logic [9:0]       m10;
  logic [7:0]       e8;
  logic [7:0]       sub_shift;

  always_comb begin
    e5        = operand_bits[14:10];
    m10       = operand_bits[9:0];
    e8        = operand_bits[30:23];
    sub_shift = hsfc_pkg::SubnExpStart - e8;
    dec_next       = '0;
    dec_next.mode  = mode;
    dec_next.cls   = hsfc_pkg::CLS_ZERO;
    if (mode == hsfc_pkg::ModeHalfToSgl) begin
      dec_next.sign = operand_bits[15];
      dec_next.mant = {14'b0, m10};
      if (e5 == 5'd0) begin
        if (m10 != 10'd0) begin
          dec_next.cls   = hsfc_pkg::CLS_SUB;
          dec_next.shamt = hsfc_pkg::lzc10(m10) + 4'd1;
          dec_next.expo  = hsfc_pkg::SubnExpStart - {4'b0, dec_next.shamt};
        end
      end else begin
        dec_next.cls = hsfc_pkg::CLS_NORM;
        if (e5 == hsfc_pkg::HalfExpAllOnes) begin
          dec_next.expo = hsfc_pkg::SglExpAllOnes;
        end else begin
          dec_next.expo = {3'b0, e5} + hsfc_pkg::HalfToSglRebias;
        end
      end
    end else begin
      dec_next.sign = operand_bits[31];
      if (e8 < hsfc_pkg::SglExpZeroBelow) begin
        dec_next.cls = hsfc_pkg::CLS_ZERO;
      end else if (e8 <= hsfc_pkg::SglExpSubMax) begin
        dec_next.cls   = hsfc_pkg::CLS_SUB;
        dec_next.shamt = sub_shift[3:0];
        dec_next.mant  = {1'b1, operand_bits[22:0]};
      end else if (e8 >= hsfc_pkg::SglExpOverflow) begin
        dec_next.cls = hsfc_pkg::CLS_INF;
      end else begin
        dec_next.cls  = hsfc_pkg::CLS_NORM;
        dec_next.expo = e8 - hsfc_pkg::HalfToSglRebias;
        dec_next.mant = {1'b0, operand_bits[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= start;
    end
    dec <= dec_next;
  end

endmodule

`default_nettype wire

>>> src/hsfc_align.sv
// Second stage: normalises half subnormals and denormalises single values bound for half subnormals.
`default_nettype none

module hsfc_align (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              dec_valid,
  input  wire hsfc_pkg::stage_t  dec,
  output logic                   aln_valid,
  output hsfc_pkg::stage_t       aln
);

  hsfc_pkg::stage_t aln_next;
  logic [10:0]      left;

  always_comb begin
    aln_next = dec;
    left     = {1'b0, dec.mant[9:0]} << dec.shamt;
    if (dec.cls == hsfc_pkg::CLS_SUB) begin
      if (dec.mode == hsfc_pkg::ModeHalfToSgl) begin
        aln_next.mant = {14'b0, left[9:0]};
      end else begin
        aln_next.mant = dec.mant >> dec.shamt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aln_valid <= 1'b0;
    end else begin
      aln_valid <= dec_valid;
    end
    aln <= aln_next;
  end

endmodule

`default_nettype wire

>>> src/hsfc_pack.sv
// Third stage: rounds half results and assembles the output word.
`default_nettype none

module hsfc_pack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              aln_valid,
  input  wire hsfc_pkg::stage_t  aln,
  output logic                   done,
  output logic [31:0]            result_bits
);

  logic [31:0] result_next;
  logic [24:0] rsum;
  logic [14:0] half_mag;

  always_comb begin
    rsum     = {1'b0, aln.mant} + hsfc_pkg::RoundAdd;
    half_mag = {aln.expo[4:0], 10'b0} + {3'b0, rsum[24:13]};
    if (aln.mode == hsfc_pkg::ModeHalfToSgl) begin
      case (aln.cls)
        hsfc_pkg::CLS_ZERO: result_next = {aln.sign, 31'b0};
        default:            result_next = {aln.sign, aln.expo, aln.mant[9:0], 13'b0};
      endcase
    end else begin
      case (aln.cls)
        hsfc_pkg::CLS_ZERO: result_next = {16'b0, aln.sign, 15'b0};
        hsfc_pkg::CLS_INF:  result_next = {16'b0, aln.sign, hsfc_pkg::HalfInfinity};
        default:            result_next = {16'b0, aln.sign, half_mag};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= aln_valid;
    end
    result_bits <= result_next;
  end

endmodule

`default_nettype wire

>>> src/half_single_float_converter.sv
// Top level of the binary16/binary32 converter: three register stages in a row.
//
//   Channel   Handshake         Payload
//   -------   ---------------   ------------------------
//   input     start, busy       mode, operand_bits
//   output    done (strobe)     result_bits
//
// A word taken at a start edge is registered in turn by the decode, align
// and pack stages; done is registered together with the packed result. A
// new word may be started in every cycle; busy is always low because
// nothing in the pipeline ever waits. Synchronous reset clears the valid
// bits of all three stages. The receiver cannot stall, so done is high for
// exactly one cycle per word.
`default_nettype none

module half_single_float_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [31:0] operand_bits,
  output logic             done,
  output logic [31:0]      result_bits
);

  logic             dec_valid;
  hsfc_pkg::stage_t dec;
  logic             aln_valid;
  hsfc_pkg::stage_t aln;

  assign busy = 1'b0;

  hsfc_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .operand_bits (operand_bits),
    .dec_valid    (dec_valid),
    .dec          (dec)
  );

  hsfc_align u_align (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec       (dec),
    .aln_valid (aln_valid),
    .aln       (aln)
  );

  hsfc_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .aln_valid   (aln_valid),
    .aln         (aln),
    .done        (done),
    .result_bits (result_bits)
  );

endmodule

`default_nettype wire
